// ----- rtl/core/lcdnp_pkg.sv -----
// Shared types, codes and constants of the character-LCD nibble port sequencer.
package lcdnp_pkg;

  // Request codes carried by the func field.
  typedef enum logic [3:0] {
    FUNC_CHAR       = 4'd0,
    FUNC_SET_CURSOR = 4'd1,
    FUNC_CLEAR      = 4'd2,
    FUNC_HOME       = 4'd3,
    FUNC_SCROLL     = 4'd4,
    FUNC_DISP_FLAG  = 4'd5,
    FUNC_BACKLIGHT  = 4'd6,
    FUNC_GLYPH_ROW  = 4'd7,
    FUNC_INIT       = 4'd8
  } func_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_LINES   = 1'b1
  } cfg_reg_e;

  // Display flag selections.
  typedef enum logic [1:0] {
    FLAG_DISPLAY = 2'd0,
    FLAG_CURSOR  = 2'd1,
    FLAG_BLINK   = 2'd2
  } flag_sel_e;

  typedef enum logic {
    JOB_STATUS = 1'b0,
    JOB_BYTES  = 1'b1
  } job_kind_e;

  // One classified request as it waits between the front and the back end.
  typedef struct packed {
    job_kind_e        kind;
    logic             init;       // emit the forced 4-bit wake-up prefix first
    logic             backlight;
    logic [4:0]       last_step;  // step number of the final word
    logic [3:0]       rs;         // register select per controller byte
    logic [3:0][7:0]  bytes;      // controller bytes, entry 0 first
  } job_t;

  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_SET_CGRAM   = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;

  localparam logic [7:0] DISP_ON         = 8'h04;
  localparam logic [7:0] CURSOR_ON       = 8'h02;
  localparam logic [7:0] BLINK_ON        = 8'h01;
  localparam logic [7:0] DISP_CTRL_RESET = 8'h08;
  localparam logic [7:0] ROW1_OFFSET     = 8'h40;

  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;

  localparam logic [5:0] COLUMNS_RESET   = 6'd16;
  localparam logic [2:0] LINES_RESET     = 3'd2;
  localparam logic [2:0] MAX_LINES       = 3'd4;

  // Wake-up prefix: one idle word, then nibbles 3,3,3,2 each with EN high then low.
  localparam logic [4:0] INIT_PREFIX_LEN = 5'd9;
  localparam logic [3:0] INIT_NIB_WAKE   = 4'h3;
  localparam logic [3:0] INIT_NIB_4BIT   = 4'h2;

  // Display RAM address command for a cursor position.
  function automatic logic [7:0] ddram_addr(input logic [5:0] col, input logic [1:0] row,
                                            input logic [5:0] columns);
    logic [7:0] off;
    off = {2'b00, col};
    if (row[0]) off = off + ROW1_OFFSET;
    if (row[1]) off = off + {2'b00, columns};
    return CMD_SET_DDRAM | off;
  endfunction

  // Step number of the last word of a job with n controller bytes.
  function automatic logic [4:0] last_step_for(input logic [2:0] n);
    return INIT_PREFIX_LEN - 5'd1 + {n, 2'b00};
  endfunction

endpackage

// ----- rtl/core/lcdnp_front.sv -----
// Front end: takes requests, tracks cursor and display state, and builds jobs.
module lcdnp_front import lcdnp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic [5:0] target_col_i,
  input  logic [2:0] target_row_i,
  input  logic [1:0] flag_select_i,
  input  logic       flag_value_i,
  input  logic [2:0] glyph_index_i,
  input  logic [2:0] glyph_line_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [5:0] columns_q;
  logic [2:0] lines_q;
  logic [5:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic [7:0] dctrl_q, dctrl_d;
  logic       bl_q, bl_d;

  logic       accept;
  logic       has_job;
  logic [2:0] eff_lines;
  logic       mv_req;
  logic [5:0] mv_col;
  logic [2:0] mv_row;
  logic [7:0] flag_bit;
  job_t       job;

  assign accept     = in_valid_i & ~q_full_i;
  assign in_stall_o = q_full_i;
  assign eff_lines  = (lines_q > MAX_LINES) ? MAX_LINES : lines_q;

  always_comb begin
    case (flag_select_i)
      FLAG_DISPLAY: flag_bit = DISP_ON;
      FLAG_CURSOR:  flag_bit = CURSOR_ON;
      FLAG_BLINK:   flag_bit = BLINK_ON;
      default:      flag_bit = 8'h00;
    endcase
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    dctrl_d = dctrl_q;
    bl_d    = bl_q;
    has_job = 1'b0;
    mv_req  = 1'b0;
    mv_col  = 6'd0;
    mv_row  = 3'd0;
    job           = '0;
    job.kind      = JOB_BYTES;
    job.backlight = bl_q;
    job.last_step = last_step_for(3'd1);

    case (func_i)
      FUNC_CHAR: begin
        if (data_byte_i == CHAR_NEWLINE) begin
          if ({1'b0, row_q} + 3'd1 < eff_lines) begin
            mv_req = 1'b1;
            mv_row = {1'b0, row_q} + 3'd1;
          end
        end else if (col_q < columns_q) begin
          has_job      = 1'b1;
          job.bytes[0] = data_byte_i;
          job.rs[0]    = 1'b1;
          col_d        = col_q + 6'd1;
        end
      end
      FUNC_SET_CURSOR: begin
        mv_req = 1'b1;
        mv_col = target_col_i;
        mv_row = target_row_i;
      end
      FUNC_CLEAR, FUNC_HOME: begin
        has_job      = 1'b1;
        job.bytes[0] = (func_i == FUNC_CLEAR) ? CMD_CLEAR : CMD_HOME;
        col_d        = 6'd0;
        row_d        = 2'd0;
      end
      FUNC_SCROLL: begin
        has_job      = 1'b1;
        job.bytes[0] = flag_value_i ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
      end
      FUNC_DISP_FLAG: begin
        has_job      = 1'b1;
        dctrl_d      = flag_value_i ? (dctrl_q | flag_bit) : (dctrl_q & ~flag_bit);
        job.bytes[0] = dctrl_d;
      end
      FUNC_BACKLIGHT: begin
        has_job       = 1'b1;
        bl_d          = flag_value_i;
        job.backlight = flag_value_i;
        job.bytes[0]  = dctrl_q;
      end
      FUNC_GLYPH_ROW: begin
        has_job = 1'b1;
        if (glyph_line_i == 3'd0) begin
          job.bytes[0]  = CMD_SET_CGRAM | {2'b00, glyph_index_i, 3'b000};
          job.bytes[1]  = data_byte_i;
          job.rs[1]     = 1'b1;
          job.last_step = last_step_for(3'd2);
        end else if (glyph_line_i == 3'd7) begin
          job.bytes[0]  = data_byte_i;
          job.rs[0]     = 1'b1;
          job.bytes[1]  = ddram_addr(col_q, row_q, columns_q);
          job.last_step = last_step_for(3'd2);
        end else begin
          job.bytes[0] = data_byte_i;
          job.rs[0]    = 1'b1;
        end
      end
      FUNC_INIT: begin
        has_job       = 1'b1;
        job.init      = 1'b1;
        dctrl_d       = dctrl_q | DISP_ON;
        job.bytes[0]  = CMD_FUNC_SET;
        job.bytes[1]  = dctrl_d;
        job.bytes[2]  = CMD_CLEAR;
        job.bytes[3]  = CMD_ENTRY_MODE;
        job.last_step = last_step_for(3'd4);
        col_d         = 6'd0;
        row_d         = 2'd0;
      end
      default: begin
        has_job = 1'b0;
      end
    endcase

    // Cursor moves share the range check; a miss yields a single status word.
    if (mv_req) begin
      has_job = 1'b1;
      if (mv_col >= columns_q || mv_row >= eff_lines) begin
        job.kind = JOB_STATUS;
      end else begin
        col_d        = mv_col;
        row_d        = mv_row[1:0];
        job.bytes[0] = ddram_addr(mv_col, mv_row[1:0], columns_q);
      end
    end
  end

  assign push_o = accept & has_job;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      lines_q   <= LINES_RESET;
      col_q     <= 6'd0;
      row_q     <= 2'd0;
      dctrl_q   <= DISP_CTRL_RESET;
      bl_q      <= 1'b1;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_COLUMNS) columns_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == REG_LINES)   lines_q   <= cfg_data_i[2:0];
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        dctrl_q <= dctrl_d;
        bl_q    <= bl_d;
      end
    end
  end

endmodule

// ----- rtl/core/lcdnp_queue.sv -----
// Small job queue between the front end and the back end.
module lcdnp_queue import lcdnp_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/core/lcdnp_back.sv -----
// Back end: expands the head job into expander port words, one per cycle while the output is not stalled.
module lcdnp_back import lcdnp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] port_byte_o,
  output logic       port_valid_o,
  output logic       status_o,
  output logic       last_o
);

  logic [4:0] step_q, step_d;
  logic [4:0] eff_step;
  logic [4:0] byte_step;
  logic [3:0] pre_k;
  logic [1:0] bidx;
  logic [1:0] nib;
  logic [7:0] cur_val;
  logic [3:0] nib_val;
  logic [3:0] pre_nib;
  logic       emit;
  logic       is_last;
  logic [7:0] word;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       pv_q, st_q, last_q;

  // Jobs without the wake-up prefix start right at the controller bytes.
  assign eff_step  = head_i.init ? step_q : step_q + INIT_PREFIX_LEN;
  assign byte_step = eff_step - INIT_PREFIX_LEN;
  assign bidx      = byte_step[3:2];
  assign nib       = byte_step[1:0];
  assign pre_k     = eff_step[3:0] - 4'd1;
  assign cur_val   = head_i.bytes[bidx];
  assign nib_val   = nib[1] ? cur_val[3:0] : cur_val[7:4];
  assign pre_nib   = (pre_k[3:1] == 3'd3) ? INIT_NIB_4BIT : INIT_NIB_WAKE;

  always_comb begin
    if (eff_step < INIT_PREFIX_LEN) begin
      if (eff_step == 5'd0) word = 8'h00;
      else                  word = {pre_nib, 1'b0, ~pre_k[0], 2'b00};
    end else begin
      word = {nib_val, head_i.backlight, ~nib[0], 1'b0, head_i.rs[bidx]};
    end
  end

  assign is_last = (head_i.kind == JOB_STATUS) || (eff_step == head_i.last_step);
  assign emit    = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign pop_o   = emit & is_last;

  always_comb begin
    step_d = step_q;
    if (pop_o)     step_d = 5'd0;
    else if (emit) step_d = step_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      last_q <= is_last;
      if (head_i.kind == JOB_STATUS) begin
        byte_q <= 8'h00;
        pv_q   <= 1'b0;
        st_q   <= 1'b1;
      end else begin
        byte_q <= word;
        pv_q   <= 1'b1;
        st_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign port_byte_o  = byte_q;
  assign port_valid_o = pv_q;
  assign status_o     = st_q;
  assign last_o       = last_q;

endmodule

// ----- rtl/core/char_lcd_nibble_port_sequencer.sv -----
// Character-LCD nibble port sequencer: requests in, ordered expander port words out.
//
// This block turns character-LCD requests (characters, cursor moves, clear, home,
// scroll, display flags, backlight, custom glyph rows and init) into the stream of
// port words for an 8-bit expander that drives a 4-bit HD44780-style controller:
// bit 0 is RS, bit 2 is EN, bit 3 is the backlight and bits 7:4 carry the nibble.
// Every controller byte becomes four words (high nibble with EN set, then clear,
// then the low nibble the same way). A front end accepts one request per cycle
// while the job queue has room, updates cursor, display-control and backlight
// state at once, and queues a job; a back end drains the job queue and presents
// one word per cycle through an output register unless the output is stalled.
// A request that sends one controller byte yields four words, a glyph row that
// opens a slot or restores the cursor eight, init 25, a cursor range error one
// status word, and requests that produce nothing (dropped characters, newline on
// the last row, unused codes) none. While the job queue (QueueDepth jobs) has room
// the input is never stalled, so a new request is taken while earlier words go out.
// Configuration (columns, lines) must be written only while the block is idle.
module char_lcd_nibble_port_sequencer import lcdnp_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic [5:0] target_col_i,
  input  logic [2:0] target_row_i,
  input  logic [1:0] flag_select_i,
  input  logic       flag_value_i,
  input  logic [2:0] glyph_index_i,
  input  logic [2:0] glyph_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] port_byte_o,
  output logic       port_valid_o,
  output logic       status_o,
  output logic       last_o
);

  logic push, full, pop, empty;
  job_t job_in, head;

  // Request decode and architectural state.
  lcdnp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .flag_select_i(flag_select_i),
    .flag_value_i (flag_value_i),
    .glyph_index_i(glyph_index_i),
    .glyph_line_i (glyph_line_i),
    .q_full_i     (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  // Jobs waiting for the back end; lets each side stall on its own.
  lcdnp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  // Word sequencing and the registered output word.
  lcdnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .port_byte_o (port_byte_o),
    .port_valid_o(port_valid_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ----- rtl/core/lcdnp_checker.sv -----
// Port-level checks for the character-LCD nibble port sequencer, bound to the top level.
module lcdnp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] port_byte_o,
  input logic       port_valid_o,
  input logic       status_o,
  input logic       last_o
);

  // A stalled word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(port_byte_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // A status-only word is a lone error word that ends its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !port_valid_o |-> status_o && last_o && port_byte_o == 8'h00)
    else $error("malformed status word");

  // Port words never carry an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && port_valid_o |-> !status_o)
    else $error("port word flagged with error");

  // Every request ends with EN low, so a word with EN high is never the last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && port_valid_o && port_byte_o[2] |-> !last_o)
    else $error("request ended with EN high");

endmodule

bind char_lcd_nibble_port_sequencer lcdnp_checker u_lcdnp_checker (.*);
